/* sv/hrfu_pkg.sv */
// Shared types and constants of the H.264 RTP FU-A packetiser.
// No dependencies; every other file refers to it by scoped names.
package hrfu_pkg;

	localparam int LEN_W      = 20;
	localparam int PAY_W      = 13;
	localparam int TS_INC_W   = 17;
	localparam int SEQ_W      = 16;
	localparam int TS_W       = 32;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 17;

	localparam logic [PAY_W-1:0]    PAYLOAD_MIN   = 13'd16;
	localparam logic [PAY_W-1:0]    PAYLOAD_MAX   = 13'd4096;
	localparam logic [PAY_W-1:0]    PAYLOAD_RESET = 13'd1400;
	localparam logic [TS_INC_W-1:0] TS_INC_RESET  = 17'd3600;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TS_INCREMENT = 4'd1;

	localparam logic [7:0] NRI_MASK  = 8'h60;
	localparam logic [7:0] TYPE_MASK = 8'h1f;
	localparam logic [7:0] FU_A_TYPE = 8'd28;
	localparam logic [7:0] FU_S_BIT  = 8'h80;
	localparam logic [7:0] FU_E_BIT  = 8'h40;
	localparam logic [7:0] NAL_SPS   = 8'd7;
	localparam logic [7:0] NAL_PPS   = 8'd8;

	localparam int RES_MAX = 3;

	typedef struct packed {
		logic [PAY_W-1:0]    payload;
		logic [TS_INC_W-1:0] ts_inc;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
		logic       stop;
	} res_t;

	typedef struct packed {
		res_t [RES_MAX-1:0] r;
		logic [1:0]         cnt;
		logic [SEQ_W-1:0]   seq;
		logic [TS_W-1:0]    ts;
	} bundle_t;

endpackage

/* sv/hrfu_ifs.sv */
// Handshake channels of the packetiser: NAL byte input, RTP byte output and
// register write. Depends on hrfu_pkg for the field widths.
interface hrfu_in_if;
	logic                           valid;
	logic                           ready;
	logic [7:0]                     data_byte;
	logic                           unit_first;
	logic [hrfu_pkg::LEN_W-1:0]     unit_length;
	modport source (output valid, data_byte, unit_first, unit_length, input ready);
	modport sink (input valid, data_byte, unit_first, unit_length, output ready);
endinterface

interface hrfu_out_if;
	logic                           valid;
	logic                           ready;
	logic [7:0]                     out_byte;
	logic                           packet_start;
	logic                           packet_end;
	logic [hrfu_pkg::SEQ_W-1:0]     seq_number;
	logic [hrfu_pkg::TS_W-1:0]      timestamp;
	logic                           last_of_run;
	modport source (output valid, out_byte, packet_start, packet_end, seq_number,
		timestamp, last_of_run, input ready);
	modport sink (input valid, out_byte, packet_start, packet_end, seq_number,
		timestamp, last_of_run, output ready);
endinterface

interface hrfu_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [hrfu_pkg::CFG_IDX_W-1:0]    index;
	logic [hrfu_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/h264_rtp_fua_packetizer.sv */
// Top level of the H.264 RTP packetiser (single NAL unit and FU-A modes).
// Depends on hrfu_pkg, hrfu_ifs, hrfu_cfg, hrfu_core and hrfu_expand.
//
//  channel  modport  moves                      word
//  nal      sink     NAL unit bytes in          data_byte, unit_first, unit_length
//  rtp      source   RTP payload bytes out      out_byte, marks, seq_number, timestamp
//  cfg      sink     register writes            index, data
//
// One NAL byte a cycle enters the input register while nal is ready; its
// bundle is combinational, the state is registered as the byte moves on, and the
// result register serialises it. A byte opening an FU-A chunk gives three words
// and holds nal until the last leaves; any other byte gives at most one word,
// one a cycle while rtp is ready. Reset clears the packetising state and loads
// the register defaults. A stall on rtp holds the result register; nal takes one more word meanwhile.
module h264_rtp_fua_packetizer (
	input  logic        clk,
	input  logic        arst_n,
	hrfu_in_if.sink     nal,
	hrfu_out_if.source  rtp,
	hrfu_cfg_if.sink    cfg
);
	hrfu_pkg::cfg_t    regs;
	hrfu_pkg::bundle_t bnd;
	logic              bnd_valid;
	logic              bnd_ready;

	hrfu_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	hrfu_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.nal       (nal),
		.regs      (regs),
		.bnd_valid (bnd_valid),
		.bnd_ready (bnd_ready),
		.bnd       (bnd)
	);

	hrfu_expand u_expand (
		.clk       (clk),
		.arst_n    (arst_n),
		.bnd_valid (bnd_valid),
		.bnd_ready (bnd_ready),
		.bnd       (bnd),
		.rtp       (rtp)
	);

	// a packet always closes on a data byte, the last word of its run
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rtp.valid && rtp.packet_end |-> rtp.last_of_run)
		else $error("packet end on a word that is not last of run");

	// a chunk opening carries indicator then header, neither closing the packet
	a_chunk_shape: assert property (@(posedge clk) disable iff (!arst_n)
		bnd_valid && bnd.cnt == 2'd3 |->
			bnd.r[0].start && !bnd.r[0].stop && !bnd.r[1].start && !bnd.r[1].stop)
		else $error("malformed FU-A chunk opening");

	// a bundle handed on holds one or three words
	a_bundle_count: assert property (@(posedge clk) disable iff (!arst_n)
		bnd_valid |-> bnd.cnt == 2'd1 || bnd.cnt == 2'd3)
		else $error("bundle with bad word count");

	// a start word opens a run
	a_start_first: assert property (@(posedge clk) disable iff (!arst_n)
		rtp.valid && rtp.ready && !rtp.last_of_run |=> !(rtp.valid && rtp.packet_start))
		else $error("packet start in the middle of a run");
endmodule

/* sv/hrfu_cfg.sv */
// Register file of the packetiser: payload size (clamped on write) and
// timestamp step. Depends on hrfu_pkg and hrfu_ifs.
module hrfu_cfg (
	input  logic              clk,
	input  logic              arst_n,
	hrfu_cfg_if.sink          cfg,
	output hrfu_pkg::cfg_t    regs
);
	logic [hrfu_pkg::PAY_W-1:0]    payload_q;
	logic [hrfu_pkg::TS_INC_W-1:0] ts_inc_q;
	logic [hrfu_pkg::PAY_W-1:0]    wr_payload;
	logic [hrfu_pkg::PAY_W-1:0]    clamped;

	assign cfg.ready  = 1'b1;
	assign wr_payload = cfg.data[hrfu_pkg::PAY_W-1:0];

	always_comb begin
		clamped = wr_payload;
		if (wr_payload < hrfu_pkg::PAYLOAD_MIN)
			clamped = hrfu_pkg::PAYLOAD_MIN;
		else if (wr_payload > hrfu_pkg::PAYLOAD_MAX)
			clamped = hrfu_pkg::PAYLOAD_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_q <= hrfu_pkg::PAYLOAD_RESET;
			ts_inc_q  <= hrfu_pkg::TS_INC_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				hrfu_pkg::REG_MAX_PAYLOAD:  payload_q <= clamped;
				hrfu_pkg::REG_TS_INCREMENT: ts_inc_q  <= cfg.data[hrfu_pkg::TS_INC_W-1:0];
				default: ;
			endcase
		end
	end

	assign regs.payload = payload_q;
	assign regs.ts_inc  = ts_inc_q;
endmodule

/* sv/hrfu_core.sv */
// Input register and packetising state: turns one NAL byte into a bundle of
// up to three payload words. Depends on hrfu_pkg and hrfu_ifs.
module hrfu_core (
	input  logic               clk,
	input  logic               arst_n,
	hrfu_in_if.sink            nal,
	input  hrfu_pkg::cfg_t     regs,
	output logic               bnd_valid,
	input  logic               bnd_ready,
	output hrfu_pkg::bundle_t  bnd
);
	// input stage
	logic                        v_s1;
	logic [7:0]                  byte_s1;
	logic                        first_s1;
	logic [hrfu_pkg::LEN_W-1:0]  len_s1;

	// packetising state
	logic [7:0]                  nal_header_q;
	logic [hrfu_pkg::LEN_W-1:0]  bytes_left_q;
	logic [hrfu_pkg::PAY_W-1:0]  chunk_fill_q;
	logic                        frag_q;
	logic                        first_chunk_q;
	logic [hrfu_pkg::SEQ_W-1:0]  seq_q;
	logic [hrfu_pkg::TS_W-1:0]   ts_q;

	logic [7:0]                  nal_header_n;
	logic [hrfu_pkg::LEN_W-1:0]  bytes_left_n;
	logic [hrfu_pkg::PAY_W-1:0]  chunk_fill_n;
	logic                        frag_n;
	logic                        first_chunk_n;
	logic [hrfu_pkg::SEQ_W-1:0]  seq_n;
	logic [hrfu_pkg::TS_W-1:0]   ts_n;

	logic [hrfu_pkg::LEN_W-1:0]  len1;
	logic [hrfu_pkg::LEN_W-1:0]  left_dec;
	logic [hrfu_pkg::LEN_W-1:0]  pay_ext;
	logic [hrfu_pkg::PAY_W-1:0]  fill_inc;
	logic [hrfu_pkg::SEQ_W-1:0]  seq_base;
	logic [7:0]                  hdr_cur;
	logic [7:0]                  fu_hdr;
	logic                        finish;
	logic                        pkt_done;
	logic                        stop;
	logic                        adv;
	hrfu_pkg::bundle_t           b;

	assign pay_ext  = hrfu_pkg::LEN_W'(regs.payload);
	assign len1     = (len_s1 == '0) ? hrfu_pkg::LEN_W'(1) : len_s1;
	assign left_dec = bytes_left_q - hrfu_pkg::LEN_W'(1);
	assign fill_inc = chunk_fill_q + hrfu_pkg::PAY_W'(1);
	assign hdr_cur  = first_s1 ? byte_s1 : nal_header_q;

	always_comb begin
		nal_header_n  = nal_header_q;
		bytes_left_n  = bytes_left_q;
		chunk_fill_n  = chunk_fill_q;
		frag_n        = frag_q;
		first_chunk_n = first_chunk_q;
		seq_base      = seq_q;
		finish        = 1'b0;
		pkt_done      = 1'b0;
		stop          = 1'b0;
		fu_hdr        = nal_header_q & hrfu_pkg::TYPE_MASK;
		b             = '0;
		b.ts          = ts_q;
		if (first_s1) begin
			// abandon a running unit; an open packet still uses up its number
			if (bytes_left_q != '0 && (!frag_q || chunk_fill_q != '0))
				seq_base = seq_q + hrfu_pkg::SEQ_W'(1);
			nal_header_n  = byte_s1;
			bytes_left_n  = len1 - hrfu_pkg::LEN_W'(1);
			chunk_fill_n  = '0;
			first_chunk_n = 1'b1;
			if (len1 <= pay_ext) begin
				frag_n   = 1'b0;
				stop     = (len1 == hrfu_pkg::LEN_W'(1));
				b.cnt    = 2'd1;
				b.r[0]   = '{data: byte_s1, start: 1'b1, stop: stop};
				pkt_done = stop;
				finish   = stop;
			end else begin
				frag_n = 1'b1;
			end
		end else if (bytes_left_q != '0) begin
			bytes_left_n = left_dec;
			if (!frag_q) begin
				stop     = (bytes_left_q == hrfu_pkg::LEN_W'(1));
				b.cnt    = 2'd1;
				b.r[0]   = '{data: byte_s1, start: 1'b0, stop: stop};
				pkt_done = stop;
				finish   = stop;
			end else begin
				stop = (fill_inc >= regs.payload) || (bytes_left_q == hrfu_pkg::LEN_W'(1));
				if (first_chunk_q)
					fu_hdr = fu_hdr | hrfu_pkg::FU_S_BIT;
				else if (bytes_left_q <= pay_ext)
					fu_hdr = fu_hdr | hrfu_pkg::FU_E_BIT;
				if (chunk_fill_q == '0) begin
					b.cnt  = 2'd3;
					b.r[0] = '{data: (nal_header_q & hrfu_pkg::NRI_MASK) | hrfu_pkg::FU_A_TYPE,
						start: 1'b1, stop: 1'b0};
					b.r[1] = '{data: fu_hdr, start: 1'b0, stop: 1'b0};
					b.r[2] = '{data: byte_s1, start: 1'b0, stop: stop};
				end else begin
					b.cnt  = 2'd1;
					b.r[0] = '{data: byte_s1, start: 1'b0, stop: stop};
				end
				chunk_fill_n = fill_inc;
				if (stop) begin
					pkt_done      = 1'b1;
					chunk_fill_n  = '0;
					first_chunk_n = 1'b0;
					finish        = (left_dec == '0);
				end
			end
		end
		b.seq = seq_base;
		seq_n = pkt_done ? seq_base + hrfu_pkg::SEQ_W'(1) : seq_base;
		ts_n  = ts_q;
		if (finish) begin
			frag_n        = 1'b0;
			first_chunk_n = 1'b1;
			chunk_fill_n  = '0;
			// parameter sets leave the timestamp where it is
			if ((hdr_cur & hrfu_pkg::TYPE_MASK) != hrfu_pkg::NAL_SPS &&
				(hdr_cur & hrfu_pkg::TYPE_MASK) != hrfu_pkg::NAL_PPS)
				ts_n = ts_q + hrfu_pkg::TS_W'(regs.ts_inc);
		end
	end

	// a word with no result needs no room downstream
	assign adv       = v_s1 && (b.cnt == 2'd0 || bnd_ready);
	assign nal.ready = !v_s1 || adv;
	assign bnd_valid = v_s1 && b.cnt != 2'd0;
	assign bnd       = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (nal.ready) begin
			v_s1 <= nal.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (nal.valid && nal.ready) begin
			byte_s1  <= nal.data_byte;
			first_s1 <= nal.unit_first;
			len_s1   <= nal.unit_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nal_header_q  <= '0;
			bytes_left_q  <= '0;
			chunk_fill_q  <= '0;
			frag_q        <= 1'b0;
			first_chunk_q <= 1'b1;
			seq_q         <= '0;
			ts_q          <= '0;
		end else if (adv) begin
			nal_header_q  <= nal_header_n;
			bytes_left_q  <= bytes_left_n;
			chunk_fill_q  <= chunk_fill_n;
			frag_q        <= frag_n;
			first_chunk_q <= first_chunk_q == first_chunk_n ? first_chunk_q : first_chunk_n;
			seq_q         <= seq_n;
			ts_q          <= ts_n;
		end
	end
endmodule

/* sv/hrfu_expand.sv */
// Result register and serialiser: hands out a bundle's words, one a cycle while
// rtp is ready; loads the next as the last leaves. Uses hrfu_pkg and hrfu_ifs.
module hrfu_expand (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               bnd_valid,
	output logic               bnd_ready,
	input  hrfu_pkg::bundle_t  bnd,
	hrfu_out_if.source         rtp
);
	logic              v_s2;
	hrfu_pkg::bundle_t bnd_s2;
	logic [1:0]        idx_q;
	logic              last;
	logic              take;

	assign last      = (idx_q == bnd_s2.cnt - 2'd1);
	assign take      = rtp.valid && rtp.ready;
	assign bnd_ready = !v_s2 || (take && last);

	assign rtp.valid        = v_s2;
	assign rtp.out_byte     = bnd_s2.r[idx_q].data;
	assign rtp.packet_start = bnd_s2.r[idx_q].start;
	assign rtp.packet_end   = bnd_s2.r[idx_q].stop;
	assign rtp.seq_number   = bnd_s2.seq;
	assign rtp.timestamp    = bnd_s2.ts;
	assign rtp.last_of_run  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			idx_q <= '0;
		end else if (bnd_valid && bnd_ready) begin
			v_s2  <= 1'b1;
			idx_q <= '0;
		end else if (take) begin
			// drop the bundle after its last word, else advance
			if (last)
				v_s2 <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (bnd_valid && bnd_ready)
			bnd_s2 <= bnd;
	end
endmodule

/* bench/h264_rtp_fua_packetizer_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for the H.264 RTP FU-A packetiser: directed table, then random units.
// Depends on hrfu_pkg, hrfu_ifs and the h264_rtp_fua_packetizer top level.
module h264_rtp_fua_packetizer_test;

	localparam int RANDOM_ITEMS = 500;
	localparam int SETTLE       = 8;
	localparam int DRAIN        = 16;
	localparam int IDLE_LIMIT   = 1000;
	localparam logic [hrfu_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'hf;

	typedef enum logic [1:0] {
		ROW_NAL,
		ROW_SET_PAYLOAD,
		ROW_SET_TSINC,
		ROW_SET_OTHER
	} row_kind_t;

	// One directed step; the t_ fields hold a hand-written result where typed is set
	typedef struct packed {
		row_kind_t                     kind;
		logic [7:0]                    b;
		logic                          first;
		logic [hrfu_pkg::LEN_W-1:0]    len;
		logic                          typed;
		logic                          t_n;
		logic [7:0]                    t_byte;
		logic                          t_s;
		logic                          t_e;
		logic [hrfu_pkg::SEQ_W-1:0]    t_seq;
		logic [hrfu_pkg::TS_W-1:0]     t_ts;
	} step_row_t;

	typedef struct packed {
		logic [7:0]                  data;
		logic                        start;
		logic                        stop;
		logic [hrfu_pkg::SEQ_W-1:0]  seq;
		logic [hrfu_pkg::TS_W-1:0]   ts;
		logic                        last;
	} rtp_word_t;

	localparam int PLAN_N = 29;
	localparam step_row_t PLAN [PLAN_N] = '{
		'{ROW_NAL, 8'h65, 1'b1, 20'd1,       1'b1, 1'b1, 8'h65, 1'b1, 1'b1, 16'd0, 32'd0},
		'{ROW_NAL, 8'h00, 1'b0, 20'd0,       1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_NAL, 8'hff, 1'b1, 20'd0,       1'b1, 1'b1, 8'hff, 1'b1, 1'b1, 16'd1, 32'd3600},
		'{ROW_NAL, 8'h67, 1'b1, 20'd1,       1'b1, 1'b1, 8'h67, 1'b1, 1'b1, 16'd2, 32'd7200},
		'{ROW_NAL, 8'h68, 1'b1, 20'd1,       1'b1, 1'b1, 8'h68, 1'b1, 1'b1, 16'd3, 32'd7200},
		'{ROW_NAL, 8'h41, 1'b1, 20'd3,       1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_NAL, 8'h00, 1'b0, 20'hfffff,   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_NAL, 8'hff, 1'b0, 20'd0,       1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_NAL, 8'h61, 1'b1, 20'hfffff,   1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_NAL, 8'haa, 1'b0, 20'd0,       1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_NAL, 8'h55, 1'b0, 20'd0,       1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_NAL, 8'h45, 1'b1, 20'd2,       1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_NAL, 8'h12, 1'b0, 20'd0,       1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_SET_PAYLOAD, 8'h00, 1'b0, 20'd0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_NAL, 8'h3c, 1'b1, 20'd16,      1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_NAL, 8'h9d, 1'b1, 20'd17,      1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_NAL, 8'h42, 1'b1, 20'd2,       1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_NAL, 8'h80, 1'b0, 20'd0,       1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_SET_PAYLOAD, 8'h00, 1'b0, 20'h01fff, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_NAL, 8'h21, 1'b1, 20'd4096,    1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_NAL, 8'h22, 1'b1, 20'd4097,    1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_NAL, 8'h01, 1'b0, 20'd0,       1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_SET_TSINC, 8'h00, 1'b0, 20'd90000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_NAL, 8'h01, 1'b1, 20'd1,       1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_SET_TSINC, 8'h00, 1'b0, 20'd1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_NAL, 8'h1f, 1'b1, 20'd1,       1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_NAL, 8'h00, 1'b1, 20'd1,       1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_SET_OTHER, 8'h00, 1'b0, 20'h1ffff, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0},
		'{ROW_NAL, 8'h05, 1'b1, 20'd1,       1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0, 32'd0}
	};

	logic clk = 1'b0;
	logic arst_n;

	hrfu_in_if  nal_if ();
	hrfu_out_if rtp_if ();
	hrfu_cfg_if cfg_if ();

	h264_rtp_fua_packetizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.nal    (nal_if),
		.rtp    (rtp_if),
		.cfg    (cfg_if)
	);

	always #6 clk = ~clk;

	// Packetiser state as predicted by the bench
	logic [7:0]                     nal_hdr;
	logic [hrfu_pkg::LEN_W-1:0]     left_cnt;
	logic [hrfu_pkg::PAY_W-1:0]     fill_cnt;
	logic                           frag_on;
	logic                           first_chunk_on;
	logic [hrfu_pkg::SEQ_W-1:0]     seq_cnt;
	logic [hrfu_pkg::TS_W-1:0]      ts_cnt;
	logic [hrfu_pkg::PAY_W-1:0]     set_payload;
	logic [hrfu_pkg::TS_INC_W-1:0]  set_ts_inc;

	rtp_word_t rtp_expected [$];

	int nal_gap_max = 6;
	int rtp_gap_max = 6;
	int nal_items_sent = 0;
	int units_opened = 0;
	int rtp_words_checked = 0;
	int reg_writes_done = 0;
	int mismatch_count = 0;

	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatch_count++;
		$display("%0t: mismatch on %s after %0d words: got %0h, expected %0h",
			$time, what, rtp_words_checked, got, want);
	endtask

	function automatic int chunk_size();
		int p;
		p = set_payload;
		if (p < hrfu_pkg::PAYLOAD_MIN)
			p = hrfu_pkg::PAYLOAD_MIN;
		if (p > hrfu_pkg::PAYLOAD_MAX)
			p = hrfu_pkg::PAYLOAD_MAX;
		return p;
	endfunction

	function automatic void add_word(input logic [7:0] b, input logic s, input logic e);
		rtp_word_t w;
		w.data  = b;
		w.start = s;
		w.stop  = e;
		w.seq   = seq_cnt;
		w.ts    = ts_cnt;
		w.last  = 1'b0;
		rtp_expected.push_back(w);
	endfunction

	function automatic void close_unit();
		if ((nal_hdr & hrfu_pkg::TYPE_MASK) != hrfu_pkg::NAL_SPS &&
			(nal_hdr & hrfu_pkg::TYPE_MASK) != hrfu_pkg::NAL_PPS)
			ts_cnt = ts_cnt + hrfu_pkg::TS_W'(set_ts_inc);
		frag_on = 1'b0;
		first_chunk_on = 1'b1;
		fill_cnt = '0;
	endfunction

	// Work out the payload words that one accepted NAL byte gives
	task automatic pack_byte(input logic [7:0] b, input logic first,
		input logic [hrfu_pkg::LEN_W-1:0] len_in);
		int p;
		int n0;
		logic [hrfu_pkg::LEN_W-1:0] len;
		logic [7:0] fu_hdr;
		logic stop;
		p = chunk_size();
		n0 = rtp_expected.size();
		if (first) begin
			units_opened++;
			// an open packet of the abandoned unit still uses up its number
			if (left_cnt != 0 && (!frag_on || fill_cnt != 0))
				seq_cnt++;
			len = (len_in == 0) ? hrfu_pkg::LEN_W'(1) : len_in;
			nal_hdr = b;
			left_cnt = len - hrfu_pkg::LEN_W'(1);
			fill_cnt = '0;
			first_chunk_on = 1'b1;
			if (len <= p) begin
				frag_on = 1'b0;
				add_word(b, 1'b1, left_cnt == 0);
				if (left_cnt == 0) begin
					seq_cnt++;
					close_unit();
				end
			end else begin
				frag_on = 1'b1;
			end
		end else if (left_cnt != 0) begin
			if (!frag_on) begin
				stop = (left_cnt == 1);
				add_word(b, 1'b0, stop);
				left_cnt--;
				if (stop) begin
					seq_cnt++;
					close_unit();
				end
			end else begin
				if (fill_cnt == 0) begin
					fu_hdr = nal_hdr & hrfu_pkg::TYPE_MASK;
					if (first_chunk_on)
						fu_hdr = fu_hdr | hrfu_pkg::FU_S_BIT;
					else if (left_cnt <= p)
						fu_hdr = fu_hdr | hrfu_pkg::FU_E_BIT;
					add_word((nal_hdr & hrfu_pkg::NRI_MASK) | hrfu_pkg::FU_A_TYPE, 1'b1, 1'b0);
					add_word(fu_hdr, 1'b0, 1'b0);
				end
				fill_cnt++;
				stop = (fill_cnt >= p) || (left_cnt == 1);
				add_word(b, 1'b0, stop);
				left_cnt--;
				if (stop) begin
					seq_cnt++;
					fill_cnt = '0;
					first_chunk_on = 1'b0;
					if (left_cnt == 0)
						close_unit();
				end
			end
		end
		if (rtp_expected.size() > n0)
			rtp_expected[rtp_expected.size() - 1].last = 1'b1;
	endtask

	// Offer one NAL byte and hold it until taken; valid stays high afterwards
	task automatic nal_put(input logic [7:0] b, input logic first,
		input logic [hrfu_pkg::LEN_W-1:0] len);
		int gap;
		gap = $urandom_range(0, nal_gap_max);
		if (gap > 0) begin
			nal_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		nal_if.valid       <= 1'b1;
		nal_if.data_byte   <= b;
		nal_if.unit_first  <= first;
		nal_if.unit_length <= len;
		@(posedge clk);
		while (nal_if.ready !== 1'b1)
			@(posedge clk);
	endtask

	task automatic send_nal(input logic [7:0] b, input logic first,
		input logic [hrfu_pkg::LEN_W-1:0] len, input bit counted);
		nal_put(b, first, len);
		pack_byte(b, first, len);
		if (counted)
			nal_items_sent++;
	endtask

	// Write a register once the packetiser has gone quiet
	task automatic reg_write(input logic [hrfu_pkg::CFG_IDX_W-1:0] idx,
		input logic [hrfu_pkg::CFG_DATA_W-1:0] val);
		nal_if.valid <= 1'b0;
		while (rtp_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		@(posedge clk);
		while (cfg_if.ready !== 1'b1)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		case (idx)
			hrfu_pkg::REG_MAX_PAYLOAD:  set_payload = val[hrfu_pkg::PAY_W-1:0];
			hrfu_pkg::REG_TS_INCREMENT: set_ts_inc = val[hrfu_pkg::TS_INC_W-1:0];
			default: ;
		endcase
		reg_writes_done++;
	endtask

	// One random unit: mostly well formed, some cut short, some stray bytes
	task automatic send_unit();
		int p;
		int len;
		int full;
		int k;
		int kind;
		logic [7:0] hdr;
		p = chunk_size();
		hdr = 8'($urandom);
		if ($urandom_range(0, 7) == 0)
			hdr[4:0] = $urandom_range(0, 1) ? hrfu_pkg::NAL_SPS[4:0] : hrfu_pkg::NAL_PPS[4:0];
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 3))
				send_nal(8'($urandom), 1'b0, hrfu_pkg::LEN_W'($urandom), 1'b0);
		end else begin
			if (p > 64) begin
				len = $urandom_range(0, 12);
			end else begin
				case ($urandom_range(0, 6))
					0: len = $urandom_range(1, p);
					1: len = p + $urandom_range(0, 1);
					2: len = 2 * p + $urandom_range(0, 2);
					3: len = $urandom_range(0, 3);
					default: len = $urandom_range(p + 2, 3 * p);
				endcase
			end
			full = (len == 0) ? 0 : len - 1;
			k = full;
			if (kind == 1) begin
				// cut short: the next header abandons it
				if ($urandom_range(0, 1))
					len = $urandom_range(0, (1 << hrfu_pkg::LEN_W) - 1);
				full = (len == 0) ? 0 : len - 1;
				k = $urandom_range(0, (p > 64) ? 12 : 2 * p);
				if (k > full)
					k = full;
			end
			send_nal(hdr, 1'b1, hrfu_pkg::LEN_W'(len), 1'b1);
			repeat (k)
				send_nal(8'($urandom), 1'b0, hrfu_pkg::LEN_W'($urandom), 1'b1);
		end
	endtask

	// Payload side: random stalls and the word-by-word check
	initial begin
		int hold;
		rtp_word_t want;
		hold = 0;
		rtp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rtp_if.valid === 1'b1 && rtp_if.ready === 1'b1) begin
				if (rtp_expected.size() == 0) begin
					flag_mismatch("word with nothing expected", 32'(rtp_if.out_byte), 32'd0);
				end else begin
					want = rtp_expected.pop_front();
					if (rtp_if.out_byte !== want.data)
						flag_mismatch("out_byte", 32'(rtp_if.out_byte), 32'(want.data));
					if (rtp_if.packet_start !== want.start)
						flag_mismatch("packet_start", 32'(rtp_if.packet_start),
							32'(want.start));
					if (rtp_if.packet_end !== want.stop)
						flag_mismatch("packet_end", 32'(rtp_if.packet_end), 32'(want.stop));
					if (rtp_if.seq_number !== want.seq)
						flag_mismatch("seq_number", 32'(rtp_if.seq_number), 32'(want.seq));
					if (rtp_if.timestamp !== want.ts)
						flag_mismatch("timestamp", rtp_if.timestamp, want.ts);
					if (rtp_if.last_of_run !== want.last)
						flag_mismatch("last_of_run", 32'(rtp_if.last_of_run), 32'(want.last));
				end
				rtp_words_checked++;
				hold = $urandom_range(0, rtp_gap_max);
			end else if (hold > 0) begin
				hold--;
			end
			rtp_if.ready <= (hold == 0);
		end
	end

	// Give up when no word moves on any channel for too long
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((nal_if.valid === 1'b1 && nal_if.ready === 1'b1) ||
				(rtp_if.valid === 1'b1 && rtp_if.ready === 1'b1) ||
				(cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: no word moved for %0d cycles, %0d words still due",
			$time, IDLE_LIMIT, rtp_expected.size());
		$display("h264_rtp_fua_packetizer test failed");
		$finish;
	end

	initial begin
		int i;
		int n0;
		int random_base;
		logic [hrfu_pkg::CFG_DATA_W-1:0] pick;
		rtp_word_t typed_word;

		arst_n             <= 1'b0;
		nal_if.valid       <= 1'b0;
		nal_if.data_byte   <= '0;
		nal_if.unit_first  <= 1'b0;
		nal_if.unit_length <= '0;
		cfg_if.valid       <= 1'b0;
		cfg_if.index       <= '0;
		cfg_if.data        <= '0;

		nal_hdr        = '0;
		left_cnt       = '0;
		fill_cnt       = '0;
		frag_on        = 1'b0;
		first_chunk_on = 1'b1;
		seq_cnt        = '0;
		ts_cnt         = '0;
		set_payload    = hrfu_pkg::PAYLOAD_RESET;
		set_ts_inc     = hrfu_pkg::TS_INC_RESET;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < PLAN_N; i++) begin
			case (PLAN[i].kind)
				ROW_SET_PAYLOAD: reg_write(hrfu_pkg::REG_MAX_PAYLOAD,
					PLAN[i].len[hrfu_pkg::CFG_DATA_W-1:0]);
				ROW_SET_TSINC:   reg_write(hrfu_pkg::REG_TS_INCREMENT,
					PLAN[i].len[hrfu_pkg::CFG_DATA_W-1:0]);
				ROW_SET_OTHER:   reg_write(REG_UNUSED, PLAN[i].len[hrfu_pkg::CFG_DATA_W-1:0]);
				default: begin
					nal_put(PLAN[i].b, PLAN[i].first, PLAN[i].len);
					n0 = rtp_expected.size();
					pack_byte(PLAN[i].b, PLAN[i].first, PLAN[i].len);
					nal_items_sent++;
					// swap in the hand-written result, keep the predicted state
					if (PLAN[i].typed) begin
						while (rtp_expected.size() > n0)
							void'(rtp_expected.pop_back());
						if (PLAN[i].t_n) begin
							typed_word.data  = PLAN[i].t_byte;
							typed_word.start = PLAN[i].t_s;
							typed_word.stop  = PLAN[i].t_e;
							typed_word.seq   = PLAN[i].t_seq;
							typed_word.ts    = PLAN[i].t_ts;
							typed_word.last  = 1'b1;
							rtp_expected.push_back(typed_word);
						end
					end
				end
			endcase
		end

		random_base = nal_items_sent;
		while (nal_items_sent - random_base < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0: pick = hrfu_pkg::CFG_DATA_W'($urandom_range(0, 15));
					1: pick = hrfu_pkg::CFG_DATA_W'($urandom_range(4096, 8191));
					2: pick = hrfu_pkg::CFG_DATA_W'(17'h10000 | $urandom_range(16, 24));
					default: pick = hrfu_pkg::CFG_DATA_W'($urandom_range(16, 24));
				endcase
				reg_write(hrfu_pkg::REG_MAX_PAYLOAD, pick);
			end
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 5))
					0: pick = hrfu_pkg::CFG_DATA_W'(1);
					1: pick = hrfu_pkg::CFG_DATA_W'(90000);
					2: pick = hrfu_pkg::CFG_DATA_W'($urandom_range(90001, 131071));
					default: pick = hrfu_pkg::CFG_DATA_W'($urandom_range(1, 90000));
				endcase
				reg_write(hrfu_pkg::REG_TS_INCREMENT, pick);
			end
			if ($urandom_range(0, 9) == 0)
				reg_write(REG_UNUSED, hrfu_pkg::CFG_DATA_W'($urandom));
			nal_gap_max = $urandom_range(0, 1) ? 6 : 0;
			rtp_gap_max = $urandom_range(0, 1) ? 6 : 0;
			repeat ($urandom_range(2, 6))
				send_unit();
		end

		nal_if.valid <= 1'b0;
		while (rtp_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("covered %0d NAL bytes in %0d units, %0d payload words checked",
			nal_items_sent, units_opened, rtp_words_checked);
		$display("%0d register writes, %0d mismatches", reg_writes_done, mismatch_count);
		if (mismatch_count == 0)
			$display("h264_rtp_fua_packetizer test passed");
		else
			$display("h264_rtp_fua_packetizer test failed");
		$finish;
	end

endmodule

/* h264_rtp_fua_packetizer.f */
sv/hrfu_pkg.sv
sv/hrfu_ifs.sv
sv/hrfu_cfg.sv
sv/hrfu_core.sv
sv/hrfu_expand.sv
sv/h264_rtp_fua_packetizer.sv
bench/h264_rtp_fua_packetizer_test.sv
